// File: design/i2cs_pkg.sv
// Shared types, status codes and constants of the I2C transfer sequencer.
package i2cs_pkg;

	// Item commands.
	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_BEGIN = 2'd1,
		CMD_EVENT = 2'd2,
		CMD_TICK  = 2'd3
	} cmd_t;

	// Controller status codes reported with a bus event.
	localparam logic [7:0] ST_START     = 8'h08;
	localparam logic [7:0] ST_RSTART    = 8'h10;
	localparam logic [7:0] ST_AW_ACK    = 8'h18;
	localparam logic [7:0] ST_AW_NACK   = 8'h20;
	localparam logic [7:0] ST_DATA_ACK  = 8'h28;
	localparam logic [7:0] ST_DATA_NACK = 8'h30;
	localparam logic [7:0] ST_AR_ACK    = 8'h40;
	localparam logic [7:0] ST_AR_NACK   = 8'h48;
	localparam logic [7:0] ST_RX_ACK    = 8'h50;
	localparam logic [7:0] ST_RX_NACK   = 8'h58;

	// Classified bus events.
	typedef enum logic [3:0] {
		EV_START,
		EV_RSTART,
		EV_AW_ACK,
		EV_DATA_ACK,
		EV_DATA_NACK,
		EV_AR_ACK,
		EV_RX_ACK,
		EV_RX_NACK,
		EV_ADDR_NACK,
		EV_OTHER
	} evt_t;

	// Acknowledge actions.
	localparam logic [1:0] ACK_KEEP = 2'd0;
	localparam logic [1:0] ACK_ACK  = 2'd1;
	localparam logic [1:0] ACK_NACK = 2'd2;

	// Transfer status codes as shown on xfer_state.
	localparam logic [2:0] XC_IDLE      = 3'd0;
	localparam logic [2:0] XC_BUSY      = 3'd1;
	localparam logic [2:0] XC_OK        = 3'd2;
	localparam logic [2:0] XC_NO_DATA   = 3'd3;
	localparam logic [2:0] XC_ADDR_NACK = 3'd4;
	localparam logic [2:0] XC_DATA_NACK = 3'd5;
	localparam logic [2:0] XC_ARB_LOST  = 3'd6;
	localparam logic [2:0] XC_TIMEOUT   = 3'd7;

	// Transfer state machine, one-hot.
	typedef enum logic [7:0] {
		XS_IDLE      = 8'b0000_0001,
		XS_BUSY      = 8'b0000_0010,
		XS_OK        = 8'b0000_0100,
		XS_NO_DATA   = 8'b0000_1000,
		XS_ADDR_NACK = 8'b0001_0000,
		XS_DATA_NACK = 8'b0010_0000,
		XS_ARB_LOST  = 8'b0100_0000,
		XS_TIMEOUT   = 8'b1000_0000
	} xs_t;

	// Configuration register indexes.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_READ_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd2;
	localparam logic [23:0] TIMEOUT_RESET = 24'hFF_FFFF;

	// Classified item as it waits between the front and back parts.
	typedef struct packed {
		cmd_t       cmd;
		evt_t       evt;
		logic [4:0] buf_index;
		logic [7:0] data;
	} op_t;

	// Queue between the front and back parts.
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;

	function automatic logic [2:0] xs_code(xs_t xs);
		logic [2:0] code;
		unique case (xs)
			XS_IDLE:      code = XC_IDLE;
			XS_BUSY:      code = XC_BUSY;
			XS_OK:        code = XC_OK;
			XS_NO_DATA:   code = XC_NO_DATA;
			XS_ADDR_NACK: code = XC_ADDR_NACK;
			XS_DATA_NACK: code = XC_DATA_NACK;
			XS_ARB_LOST:  code = XC_ARB_LOST;
			XS_TIMEOUT:   code = XC_TIMEOUT;
			default:      code = XC_IDLE;
		endcase
		return code;
	endfunction

endpackage

// File: design/i2c_master_transfer_sequencer_core.sv
// Top level of the I2C master write-then-read transfer sequencer.
//
//   Channel   Direction  Handshake          Transfer takes place when
//   in        input      in_valid/in_stall  in_valid high, in_stall low
//   out       output     out_valid/out_stall out_valid high, out_stall low
//   cfg       input      cfg_valid/cfg_ready cfg_valid and cfg_ready high
//
// Every accepted item yields exactly one result. The block takes one item per cycle
// while in_stall is low. The input transfer writes an item into the two-entry queue;
// once it is at the head and the result register is not held by a stalled output,
// executing it reads the transmit buffer and loads the result register, which then shows it.
// The execute step, one small decode and one read of the transmit buffer, sets that rate.
// Reset clears positions, status, tick counter and configuration (timeout limit to all
// ones); the transmit buffer is not cleared and needs no clearing pass.
// A stalled output holds its result; the queue then fills and in_stall rises after two
// more transfers. cfg_ready is always high.
module i2c_master_transfer_sequencer_core import i2cs_pkg::*; #(
	parameter int BUFFER_DEPTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            cmd,
	input  logic [4:0]            buf_index,
	input  logic [7:0]            buf_data,
	input  logic [7:0]            bus_status,
	input  logic [7:0]            bus_rx_byte,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  tx_valid,
	output logic [7:0]            tx_byte,
	output logic                  set_start,
	output logic                  clear_start,
	output logic                  send_stop,
	output logic [1:0]            ack_action,
	output logic                  rx_valid,
	output logic [7:0]            rx_byte,
	output logic [4:0]            rx_index,
	output logic [2:0]            xfer_state,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Queue signals between the front and back parts.
	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_head_valid;
	op_t  q_push_op;
	op_t  q_head_op;

	// The front part classifies each item as it is accepted.
	i2cs_front u_front (
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.buf_index   (buf_index),
		.buf_data    (buf_data),
		.bus_status  (bus_status),
		.bus_rx_byte (bus_rx_byte),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_op        (q_push_op)
	);

	// The queue decouples acceptance from execution so each side stalls on its own.
	i2cs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_op    (q_push_op),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_op    (q_head_op)
	);

	// The back part carries items out in order, including buffer loads, so a load
	// is always seen by every later event.
	i2cs_back #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_valid     (q_head_valid),
		.q_op        (q_head_op),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.tx_valid    (tx_valid),
		.tx_byte     (tx_byte),
		.set_start   (set_start),
		.clear_start (clear_start),
		.send_stop   (send_stop),
		.ack_action  (ack_action),
		.rx_valid    (rx_valid),
		.rx_byte     (rx_byte),
		.rx_index    (rx_index),
		.xfer_state  (xfer_state)
	);

endmodule

// File: design/i2cs_front.sv
// Front part: input handshake and classification of items into queue entries.
module i2cs_front import i2cs_pkg::*; (
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] cmd,
	input  logic [4:0] buf_index,
	input  logic [7:0] buf_data,
	input  logic [7:0] bus_status,
	input  logic [7:0] bus_rx_byte,
	input  logic       q_full,
	output logic       q_push,
	output op_t        q_op
);

	evt_t evt;
	cmd_t cmd_c;

	assign cmd_c    = cmd_t'(cmd);
	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		unique case (bus_status)
			ST_START:     evt = EV_START;
			ST_RSTART:    evt = EV_RSTART;
			ST_AW_ACK:    evt = EV_AW_ACK;
			ST_DATA_ACK:  evt = EV_DATA_ACK;
			ST_DATA_NACK: evt = EV_DATA_NACK;
			ST_AR_ACK:    evt = EV_AR_ACK;
			ST_RX_ACK:    evt = EV_RX_ACK;
			ST_RX_NACK:   evt = EV_RX_NACK;
			ST_AW_NACK:   evt = EV_ADDR_NACK;
			ST_AR_NACK:   evt = EV_ADDR_NACK;
			default:      evt = EV_OTHER;
		endcase
	end

	// Loads carry the buffer byte, events carry the received byte.
	always_comb begin
		q_op.cmd       = cmd_c;
		q_op.evt       = evt;
		q_op.buf_index = buf_index;
		q_op.data      = (cmd_c == CMD_LOAD) ? buf_data : bus_rx_byte;
	end

endmodule

// File: design/i2cs_queue.sv
// Short queue of classified items between the front and back parts.
module i2cs_queue import i2cs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output op_t  head_op
);

	op_t                entries_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign full       = (count_q == Q_CNT_W'(Q_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_op    = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= Q_PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= Q_PTR_W'(rd_ptr_q + 1'b1);
			end
			count_q <= Q_CNT_W'(count_q + Q_CNT_W'(push) - Q_CNT_W'(pop));
		end
	end

endmodule

// File: design/i2cs_back.sv
// Back part: configuration, transfer state, transmit buffer and result register.
module i2cs_back import i2cs_pkg::*; #(
	parameter int BUFFER_DEPTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  q_valid,
	input  op_t                   q_op,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  tx_valid,
	output logic [7:0]            tx_byte,
	output logic                  set_start,
	output logic                  clear_start,
	output logic                  send_stop,
	output logic [1:0]            ack_action,
	output logic                  rx_valid,
	output logic [7:0]            rx_byte,
	output logic [4:0]            rx_index,
	output logic [2:0]            xfer_state
);

	localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam logic [IDX_W-1:0] SLOT_LAST = IDX_W'(BUFFER_DEPTH - 1);

	// Slot follows its 6-bit position modulo the buffer depth.
	function automatic logic [IDX_W-1:0] slot_next(logic [5:0] pos, logic [IDX_W-1:0] slot);
		logic [IDX_W-1:0] nxt;
		nxt = ((pos == 6'd63) || (slot == SLOT_LAST)) ? '0 : IDX_W'(slot + 1'b1);
		return nxt;
	endfunction

	function automatic logic [1:0] ack_for(logic [5:0] pos, logic [5:0] count);
		logic [1:0] act;
		act = (({1'b0, pos} + 7'd1) < {1'b0, count}) ? ACK_ACK : ACK_NACK;
		return act;
	endfunction

	logic [5:0]       write_count_q;
	logic [5:0]       read_count_q;
	logic [23:0]      timeout_limit_q;
	logic [5:0]       write_pos_q, write_pos_d;
	logic [IDX_W-1:0] wslot_q, wslot_d;
	logic [5:0]       read_pos_q, read_pos_d;
	logic [IDX_W-1:0] rslot_q, rslot_d;
	xs_t              xs_q, xs_d;
	logic [23:0]      idle_ticks_q, idle_ticks_d;

	logic [7:0]       buf_mem [BUFFER_DEPTH];
	logic [IDX_W-1:0] load_slot_lut [32];
	logic             mem_we;
	logic [IDX_W-1:0] rd_addr;

	logic             exec;
	logic             r_tx_valid, r_set_start, r_clear_start, r_send_stop, r_rx_valid;
	logic [1:0]       r_ack;
	logic [4:0]       r_rx_index;
	logic [IDX_W+4:0] rslot_ext;

	logic             out_valid_q;
	logic             tx_valid_s2, set_start_s2, clear_start_s2, send_stop_s2, rx_valid_s2;
	logic [1:0]       ack_s2;
	logic [7:0]       rd_s2, rx_byte_s2;
	logic [4:0]       rx_index_s2;
	logic [2:0]       xfer_state_s2;

	for (genvar g = 0; g < 32; g++) begin : g_lut
		assign load_slot_lut[g] = IDX_W'(g % BUFFER_DEPTH);
	end

	assign cfg_ready = 1'b1;
	assign exec      = q_valid && (!out_valid_q || !out_stall);
	assign q_pop     = exec;
	assign mem_we    = exec && (q_op.cmd == CMD_LOAD);
	assign rslot_ext = {5'd0, rslot_q};
	assign r_rx_index = rslot_ext[4:0];

	always_comb begin
		write_pos_d   = write_pos_q;
		wslot_d       = wslot_q;
		read_pos_d    = read_pos_q;
		rslot_d       = rslot_q;
		xs_d          = xs_q;
		idle_ticks_d  = idle_ticks_q;
		rd_addr       = wslot_q;
		r_tx_valid    = 1'b0;
		r_set_start   = 1'b0;
		r_clear_start = 1'b0;
		r_send_stop   = 1'b0;
		r_rx_valid    = 1'b0;
		r_ack         = ACK_KEEP;
		unique case (q_op.cmd)
			CMD_LOAD: begin
			end
			CMD_BEGIN: begin
				r_set_start  = 1'b1;
				xs_d         = XS_BUSY;
				idle_ticks_d = '0;
			end
			CMD_EVENT: begin
				idle_ticks_d = '0;
				unique case (q_op.evt)
					EV_START: begin
						rd_addr       = '0;
						write_pos_d   = 6'd1;
						wslot_d       = slot_next(6'd0, '0);
						r_tx_valid    = 1'b1;
						r_clear_start = 1'b1;
					end
					EV_RSTART: begin
						read_pos_d    = '0;
						rslot_d       = '0;
						write_pos_d   = 6'(write_pos_q + 1'b1);
						wslot_d       = slot_next(write_pos_q, wslot_q);
						r_tx_valid    = 1'b1;
						r_clear_start = 1'b1;
					end
					EV_AW_ACK: begin
						if (write_count_q == 6'd1) begin
							r_send_stop = 1'b1;
							xs_d        = XS_NO_DATA;
						end else begin
							write_pos_d = 6'(write_pos_q + 1'b1);
							wslot_d     = slot_next(write_pos_q, wslot_q);
							r_tx_valid  = 1'b1;
						end
					end
					EV_DATA_ACK: begin
						if (write_pos_q < write_count_q) begin
							write_pos_d = 6'(write_pos_q + 1'b1);
							wslot_d     = slot_next(write_pos_q, wslot_q);
							r_tx_valid  = 1'b1;
						end else if (read_count_q != '0) begin
							r_set_start = 1'b1;
						end else begin
							r_send_stop = 1'b1;
							xs_d        = XS_OK;
						end
					end
					EV_DATA_NACK: begin
						r_send_stop = 1'b1;
						xs_d        = XS_DATA_NACK;
					end
					EV_AR_ACK: begin
						r_ack = ack_for(read_pos_q, read_count_q);
					end
					EV_RX_ACK: begin
						r_rx_valid = 1'b1;
						read_pos_d = 6'(read_pos_q + 1'b1);
						rslot_d    = slot_next(read_pos_q, rslot_q);
						r_ack      = ack_for(6'(read_pos_q + 1'b1), read_count_q);
					end
					EV_RX_NACK: begin
						r_rx_valid  = 1'b1;
						read_pos_d  = 6'(read_pos_q + 1'b1);
						rslot_d     = slot_next(read_pos_q, rslot_q);
						r_send_stop = 1'b1;
						xs_d        = XS_OK;
					end
					EV_ADDR_NACK: begin
						r_send_stop = 1'b1;
						xs_d        = XS_ADDR_NACK;
					end
					EV_OTHER: begin
						xs_d = XS_ARB_LOST;
					end
				endcase
			end
			CMD_TICK: begin
				if (xs_q == XS_BUSY) begin
					if (idle_ticks_q >= timeout_limit_q) begin
						xs_d          = XS_TIMEOUT;
						idle_ticks_d  = '0;
						r_clear_start = 1'b1;
					end else begin
						idle_ticks_d = 24'(idle_ticks_q + 1'b1);
					end
				end
			end
		endcase
	end

	// Transmit buffer; read data is registered with the result.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			buf_mem[load_slot_lut[q_op.buf_index]] <= q_op.data;
		end
		if (exec) begin
			rd_s2 <= buf_mem[rd_addr];
		end
	end

	// A write to an unlisted register index is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_count_q   <= '0;
			read_count_q    <= '0;
			timeout_limit_q <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_WRITE_COUNT: write_count_q   <= cfg_data[5:0];
				CFG_READ_COUNT:  read_count_q    <= cfg_data[5:0];
				CFG_TIMEOUT:     timeout_limit_q <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_pos_q  <= '0;
			wslot_q      <= '0;
			read_pos_q   <= '0;
			rslot_q      <= '0;
			xs_q         <= XS_IDLE;
			idle_ticks_q <= '0;
		end else if (exec) begin
			write_pos_q  <= write_pos_d;
			wslot_q      <= wslot_d;
			read_pos_q   <= read_pos_d;
			rslot_q      <= rslot_d;
			xs_q         <= xs_d;
			idle_ticks_q <= idle_ticks_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			tx_valid_s2    <= r_tx_valid;
			set_start_s2   <= r_set_start;
			clear_start_s2 <= r_clear_start;
			send_stop_s2   <= r_send_stop;
			ack_s2         <= r_ack;
			rx_valid_s2    <= r_rx_valid;
			rx_byte_s2     <= r_rx_valid ? q_op.data : 8'd0;
			rx_index_s2    <= r_rx_valid ? r_rx_index : 5'd0;
			xfer_state_s2  <= xs_code(xs_d);
		end
	end

	assign out_valid   = out_valid_q;
	assign tx_valid    = tx_valid_s2;
	assign tx_byte     = tx_valid_s2 ? rd_s2 : 8'd0;
	assign set_start   = set_start_s2;
	assign clear_start = clear_start_s2;
	assign send_stop   = send_stop_s2;
	assign ack_action  = ack_s2;
	assign rx_valid    = rx_valid_s2;
	assign rx_byte     = rx_byte_s2;
	assign rx_index    = rx_index_s2;
	assign xfer_state  = xfer_state_s2;

endmodule

// File: design/i2cs_checker.sv
// Port-level checker of the I2C transfer sequencer and its bind to the top level.
module i2cs_checker import i2cs_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic                  tx_valid,
	input logic [7:0]            tx_byte,
	input logic                  set_start,
	input logic                  clear_start,
	input logic                  send_stop,
	input logic [1:0]            ack_action,
	input logic                  rx_valid,
	input logic [7:0]            rx_byte,
	input logic [4:0]            rx_index,
	input logic [2:0]            xfer_state
);

	logic [2:0] outstanding_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;

	// Items accepted whose result has not yet been transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			outstanding_q <= 3'(outstanding_q + 3'(in_xfer) - 3'(out_xfer));
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(tx_valid) && $stable(tx_byte)
			&& $stable(set_start) && $stable(clear_start) && $stable(send_stop)
			&& $stable(ack_action) && $stable(rx_valid) && $stable(rx_byte)
			&& $stable(rx_index) && $stable(xfer_state))
		else $error("stalled result changed");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> outstanding_q != 3'd0)
		else $error("result shown without an accepted item");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> outstanding_q >= 3'd2)
		else $error("input stalled while the block has room");

	a_last_byte_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rx_valid && send_stop |-> xfer_state == XC_OK)
		else $error("last received byte did not end the transfer as ok");

endmodule

bind i2c_master_transfer_sequencer_core i2cs_checker u_i2cs_checker (.*);

// File: dv/i2c_master_transfer_sequencer_core_test.sv
// Self-checking testbench for the I2C master transfer sequencer core.
module i2c_master_transfer_sequencer_core_test;
	import i2cs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// The transmit buffer depth of the instance below.
	localparam int DEPTH = 32;

	// The watchdog is sized many times over the slowest legal run. That run is about
	// 1400 items, each held off by sender gaps and receiver stalls.
	localparam int unsigned CYCLE_LIMIT = 400000;

	// Random items per configuration phase, for ten phases.
	localparam int PHASE_ITEMS = 125;
	localparam int PHASE_COUNT = 10;

	// Fixed settings of the first phases. Together they reach the extremes of the
	// three registers: a write count of one, empty and full-width counts, a timeout
	// limit of zero and of all ones.
	localparam int FIXED_PHASES = 6;
	localparam int PHASE_WCOUNT [FIXED_PHASES] = '{1, 32, 0, 63, 3, 5};
	localparam int PHASE_RCOUNT [FIXED_PHASES] = '{0, 32, 0, 63, 1, 4};
	localparam int PHASE_LIMIT [FIXED_PHASES] = '{0, 24'hFF_FFFF, 1, 2, 4, 8};

	// Every status code that the sequencer decodes; the rest count as lost arbitration.
	localparam logic [7:0] LISTED_CODES [10] = '{ST_START, ST_RSTART, ST_AW_ACK,
		ST_AW_NACK, ST_DATA_ACK, ST_DATA_NACK, ST_AR_ACK, ST_AR_NACK, ST_RX_ACK,
		ST_RX_NACK};

	// One input item as the sender presents it.
	typedef struct packed {
		cmd_t       cmd;
		logic [4:0] slot;
		logic [7:0] data;
		logic [7:0] status;
		logic [7:0] rx;
	} bus_item_t;

	// One result item: the controller action that an item calls for.
	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       set_start;
		logic       clear_start;
		logic       send_stop;
		logic [1:0] ack_action;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic [4:0] rx_index;
		logic [2:0] xfer_state;
	} bus_action_t;

	// How the receiver stalls during one stretch of cycles.
	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_TOGGLE
	} stall_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [1:0]            cmd = CMD_TICK;
	logic [4:0]            buf_index = '0;
	logic [7:0]            buf_data = '0;
	logic [7:0]            bus_status = '0;
	logic [7:0]            bus_rx_byte = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  tx_valid;
	logic [7:0]            tx_byte;
	logic                  set_start;
	logic                  clear_start;
	logic                  send_stop;
	logic [1:0]            ack_action;
	logic                  rx_valid;
	logic [7:0]            rx_byte;
	logic [4:0]            rx_index;
	logic [2:0]            xfer_state;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_WRITE_COUNT;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	i2c_master_transfer_sequencer_core #(
		.BUFFER_DEPTH(DEPTH)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.buf_index  (buf_index),
		.buf_data   (buf_data),
		.bus_status (bus_status),
		.bus_rx_byte(bus_rx_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.tx_valid   (tx_valid),
		.tx_byte    (tx_byte),
		.set_start  (set_start),
		.clear_start(clear_start),
		.send_stop  (send_stop),
		.ack_action (ack_action),
		.rx_valid   (rx_valid),
		.rx_byte    (rx_byte),
		.rx_index   (rx_index),
		.xfer_state (xfer_state),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// 8 ns clock period: 4 ns high, 4 ns low.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Predictor state. It mirrors the sequencer: its own copy of the transmit
	// buffer, both positions, the transfer status, the idle tick counter and
	// the three configuration registers with their reset values.
	// ------------------------------------------------------------------------
	logic [7:0]  tx_shadow [DEPTH];
	logic [5:0]  wr_ptr = '0;
	logic [5:0]  rd_ptr = '0;
	logic [2:0]  xfer_code = XC_IDLE;
	logic [23:0] tick_count = '0;
	logic [5:0]  cfg_wcount = '0;
	logic [5:0]  cfg_rcount = '0;
	logic [23:0] cfg_tlimit = TIMEOUT_RESET;

	// Expected controller actions, oldest first, and the items still to be sent.
	bus_action_t expected_actions [$];
	bus_item_t   pending_items [$];

	// Bookkeeping that the stimulus, the driver and the monitor share.
	int unsigned issued_items = 0;
	int unsigned accepted_items = 0;
	int unsigned checked_actions = 0;
	int unsigned timeouts_seen = 0;
	int unsigned rx_bytes_seen = 0;
	int unsigned cfg_writes = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	logic        in_taken = 1'b0;
	logic        cfg_taken = 1'b0;

	// Settings the stimulus builds its transfers for; they follow each config write.
	int gen_wcount = 0;
	int gen_rcount = 0;

	// The next transmit byte: the slot is the write position modulo the buffer
	// depth, and the position itself wraps at 64.
	function automatic logic [7:0] take_tx_byte();
		logic [7:0] b;
		b = tx_shadow[wr_ptr % DEPTH];
		wr_ptr = wr_ptr + 6'd1;
		return b;
	endfunction

	// ACK while at least one more byte beyond the next is wanted, else NACK.
	function automatic logic [1:0] next_ack();
		return (int'(rd_ptr) + 1 < int'(cfg_rcount)) ? ACK_ACK : ACK_NACK;
	endfunction

	// Advance the predictor by one accepted item and return the action it calls for.
	function automatic bus_action_t apply_item(bus_item_t it);
		bus_action_t act;
		act = '0;
		case (it.cmd)
			CMD_LOAD: tx_shadow[it.slot % DEPTH] = it.data;
			CMD_BEGIN: begin
				// Begin requests START, marks the transfer busy and clears the tick count; the positions are left as they are.
				act.set_start = 1'b1;
				xfer_code = XC_BUSY;
				tick_count = '0;
			end
			CMD_EVENT: begin
				// Any bus event restarts the timeout, whatever the status.
				tick_count = '0;
				case (it.status)
					ST_START: begin
						wr_ptr = '0;
						act.tx_valid = 1'b1;
						act.tx_byte = take_tx_byte();
						act.clear_start = 1'b1;
					end
					ST_RSTART: begin
						rd_ptr = '0;
						act.tx_valid = 1'b1;
						act.tx_byte = take_tx_byte();
						act.clear_start = 1'b1;
					end
					ST_AW_ACK: begin
						// A single byte means the address alone: nothing to write.
						if (cfg_wcount == 6'd1) begin
							act.send_stop = 1'b1;
							xfer_code = XC_NO_DATA;
						end else begin
							act.tx_valid = 1'b1;
							act.tx_byte = take_tx_byte();
						end
					end
					ST_DATA_ACK: begin
						if (wr_ptr < cfg_wcount) begin
							act.tx_valid = 1'b1;
							act.tx_byte = take_tx_byte();
						end else if (cfg_rcount != 0) begin
							act.set_start = 1'b1;
						end else begin
							act.send_stop = 1'b1;
							xfer_code = XC_OK;
						end
					end
					ST_DATA_NACK: begin
						act.send_stop = 1'b1;
						xfer_code = XC_DATA_NACK;
					end
					ST_AR_ACK: act.ack_action = next_ack();
					ST_RX_ACK: begin
						act.rx_valid = 1'b1;
						act.rx_byte = it.rx;
						act.rx_index = rd_ptr % DEPTH;
						rd_ptr = rd_ptr + 6'd1;
						act.ack_action = next_ack();
					end
					ST_RX_NACK: begin
						act.rx_valid = 1'b1;
						act.rx_byte = it.rx;
						act.rx_index = rd_ptr % DEPTH;
						rd_ptr = rd_ptr + 6'd1;
						act.send_stop = 1'b1;
						xfer_code = XC_OK;
					end
					ST_AW_NACK, ST_AR_NACK: begin
						act.send_stop = 1'b1;
						xfer_code = XC_ADDR_NACK;
					end
					default: xfer_code = XC_ARB_LOST;
				endcase
			end
			CMD_TICK: begin
				// Ticks only count while busy; a limit of zero fails the first one.
				if (xfer_code == XC_BUSY) begin
					if (tick_count >= cfg_tlimit) begin
						xfer_code = XC_TIMEOUT;
						tick_count = '0;
						act.clear_start = 1'b1;
						timeouts_seen++;
					end else begin
						tick_count = tick_count + 24'd1;
					end
				end
			end
		endcase
		act.xfer_state = xfer_code;
		if (act.rx_valid)
			rx_bytes_seen++;
		return act;
	endfunction

	// Count a failure, and print it while the log is still short.
	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch at result %0d: %s got 0x%0h, want 0x%0h",
				checked_actions, what, got, want);
	endtask

	// ------------------------------------------------------------------------
	// Monitor. Everything is sampled at the rising edge. Config writes and
	// accepted items update the predictor in the order they reach the block;
	// each accepted result is compared with the oldest expectation.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		bus_item_t   seen;
		bus_action_t got;
		bus_action_t want;
		if (arst_n) begin
			in_taken <= in_valid && !in_stall;
			cfg_taken <= cfg_valid && cfg_ready;
			if (cfg_valid && cfg_ready) begin
				cfg_writes++;
				case (cfg_index)
					CFG_WRITE_COUNT: cfg_wcount = cfg_data[5:0];
					CFG_READ_COUNT:  cfg_rcount = cfg_data[5:0];
					CFG_TIMEOUT:     cfg_tlimit = cfg_data[23:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				seen.cmd = cmd_t'(cmd);
				seen.slot = buf_index;
				seen.data = buf_data;
				seen.status = bus_status;
				seen.rx = bus_rx_byte;
				expected_actions.push_back(apply_item(seen));
				accepted_items <= accepted_items + 1;
			end
			if (out_valid && !out_stall) begin
				got = '{tx_valid, tx_byte, set_start, clear_start, send_stop, ack_action,
					rx_valid, rx_byte, rx_index, xfer_state};
				if (expected_actions.size() == 0) begin
					report_mismatch("result with nothing expected", got, 0);
				end else begin
					want = expected_actions.pop_front();
					if (got.tx_valid !== want.tx_valid)
						report_mismatch("tx_valid", got.tx_valid, want.tx_valid);
					if (got.tx_byte !== want.tx_byte)
						report_mismatch("tx_byte", got.tx_byte, want.tx_byte);
					if (got.set_start !== want.set_start)
						report_mismatch("set_start", got.set_start, want.set_start);
					if (got.clear_start !== want.clear_start)
						report_mismatch("clear_start", got.clear_start, want.clear_start);
					if (got.send_stop !== want.send_stop)
						report_mismatch("send_stop", got.send_stop, want.send_stop);
					if (got.ack_action !== want.ack_action)
						report_mismatch("ack_action", got.ack_action, want.ack_action);
					if (got.rx_valid !== want.rx_valid)
						report_mismatch("rx_valid", got.rx_valid, want.rx_valid);
					if (got.rx_byte !== want.rx_byte)
						report_mismatch("rx_byte", got.rx_byte, want.rx_byte);
					if (got.rx_index !== want.rx_index)
						report_mismatch("rx_index", got.rx_index, want.rx_index);
					if (got.xfer_state !== want.xfer_state)
						report_mismatch("xfer_state", got.xfer_state, want.xfer_state);
				end
				checked_actions++;
			end
		end
	end

	// Watchdog: a run that stalls or loses results ends here as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("watchdog expired after %0d cycles, %0d results still expected",
				cycle_count, expected_actions.size());
			$display("tb: failure");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Driver. Inputs change on the falling edge only. The sender works in
	// bursts of random length separated by random gaps; a gap of zero lets
	// two bursts run together, so stretches without idling occur as well. An
	// item that is not yet accepted stays on the pins unchanged.
	// ------------------------------------------------------------------------
	int        burst_left = 0;
	int        gap_left = 0;
	bus_item_t next_item;

	always @(negedge clk) begin : driver
		if (arst_n && (!in_valid || in_taken)) begin
			if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				next_item = pending_items.pop_front();
				in_valid <= 1'b1;
				cmd <= next_item.cmd;
				buf_index <= next_item.slot;
				buf_data <= next_item.data;
				bus_status <= next_item.status;
				bus_rx_byte <= next_item.rx;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver. It stalls on a pattern of its own that it picks anew for each random
	// stretch: no stall, light or heavy random stalls, or a stall that toggles on and off.
	stall_mode_t stall_mode = STALL_NONE;
	int          stall_run = 0;

	always @(negedge clk) begin : receiver
		if (stall_run == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_run = $urandom_range(8, 64);
		end else begin
			stall_run--;
		end
		case (stall_mode)
			STALL_NONE:   out_stall <= 1'b0;
			STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
			default:      out_stall <= !out_stall;
		endcase
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers. Items go into the pending queue; the driver takes
	// them from there.
	// ------------------------------------------------------------------------
	task automatic queue_item(cmd_t c, logic [4:0] slot, logic [7:0] data, logic [7:0] status,
		logic [7:0] rx);
		bus_item_t it;
		it = '{c, slot, data, status, rx};
		pending_items.push_back(it);
		issued_items++;
	endtask

	// Unused fields carry random values, since the block must ignore them.
	task automatic load_byte(logic [4:0] slot, logic [7:0] data);
		queue_item(CMD_LOAD, slot, data, $urandom_range(0, 255), $urandom_range(0, 255));
	endtask

	task automatic begin_transfer();
		queue_item(CMD_BEGIN, $urandom_range(0, 31), $urandom_range(0, 255),
			$urandom_range(0, 255), $urandom_range(0, 255));
	endtask

	task automatic bus_event(logic [7:0] status, logic [7:0] rx);
		queue_item(CMD_EVENT, $urandom_range(0, 31), $urandom_range(0, 255), status, rx);
	endtask

	task automatic time_tick();
		queue_item(CMD_TICK, $urandom_range(0, 31), $urandom_range(0, 255),
			$urandom_range(0, 255), $urandom_range(0, 255));
	endtask

	// A few ticks now and then between bus events. With small limits they
	// push the transfer into timeout, with larger ones they only count.
	task automatic some_ticks();
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 4)) time_tick();
	endtask

	// Occasionally break a transfer off with a NACK or a random status code.
	task automatic maybe_fault(output bit hit);
		hit = ($urandom_range(0, 29) == 0);
		if (hit) begin
			case ($urandom_range(0, 3))
				0: bus_event(ST_AW_NACK, $urandom_range(0, 255));
				1: bus_event(ST_DATA_NACK, $urandom_range(0, 255));
				2: bus_event(ST_AR_NACK, $urandom_range(0, 255));
				default: bus_event($urandom_range(0, 255), $urandom_range(0, 255));
			endcase
		end
	endtask

	// A well-formed write-then-read transfer for the current counts: START, the
	// address and data bytes, a repeated START when bytes are to be read, then
	// the received bytes, the last one NACKed. A fault may break it off early.
	task automatic run_transfer();
		int wpos;
		int k;
		bit hit;
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) load_byte($urandom_range(0, 31), $urandom_range(0, 255));
		begin_transfer();
		some_ticks();
		bus_event(ST_START, $urandom_range(0, 255));
		maybe_fault(hit);
		if (hit)
			return;
		bus_event(ST_AW_ACK, $urandom_range(0, 255));
		if (gen_wcount == 1)
			return;
		wpos = 2;
		while (wpos < gen_wcount) begin
			some_ticks();
			maybe_fault(hit);
			if (hit)
				return;
			bus_event(ST_DATA_ACK, $urandom_range(0, 255));
			wpos++;
		end
		bus_event(ST_DATA_ACK, $urandom_range(0, 255));
		if (gen_rcount == 0)
			return;
		some_ticks();
		bus_event(ST_RSTART, $urandom_range(0, 255));
		maybe_fault(hit);
		if (hit)
			return;
		bus_event(ST_AR_ACK, $urandom_range(0, 255));
		for (k = 1; k < gen_rcount; k++) begin
			some_ticks();
			bus_event(ST_RX_ACK, $urandom_range(0, 255));
		end
		bus_event(ST_RX_NACK, $urandom_range(0, 255));
	endtask

	// Noise: any command with random fields; half the events carry a listed code.
	task automatic noise_item();
		case ($urandom_range(0, 3))
			0: load_byte($urandom_range(0, 31), $urandom_range(0, 255));
			1: begin_transfer();
			2: begin
				if ($urandom_range(0, 1) == 0)
					bus_event(LISTED_CODES[$urandom_range(0, 9)], $urandom_range(0, 255));
				else
					bus_event($urandom_range(0, 255), $urandom_range(0, 255));
			end
			default: time_tick();
		endcase
	endtask

	// Write one register and hold the request until the block takes it.
	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(negedge clk);
		while (!cfg_taken);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_config(int wcount, int rcount, logic [23:0] limit);
		gen_wcount = wcount;
		gen_rcount = rcount;
		cfg_write(CFG_WRITE_COUNT, CFG_DATA_W'(wcount));
		cfg_write(CFG_READ_COUNT, CFG_DATA_W'(rcount));
		cfg_write(CFG_TIMEOUT, limit);
	endtask

	// Wait until every queued item has been taken and every result has come.
	// Each item gives one result, so the block is idle once both hold.
	task automatic wait_drained();
		@(negedge clk);
		while (accepted_items != issued_items || expected_actions.size() != 0)
			@(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Test sequence. Reset once, a directed part, then ten phases of random
	// transfers with a different register setting each. Between phases the
	// sender pauses until every expected result is back, which is also when
	// the registers are rewritten.
	// ------------------------------------------------------------------------
	initial begin : stimulus
		int ph;
		int unsigned phase_first;
		int wcount;
		int rcount;
		logic [23:0] limit;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part: two bytes out, two bytes in, a limit of three ticks.
		write_config(2, 2, 3);
		@(posedge clk);
		load_byte(5'd0, 8'h00);
		load_byte(5'd1, 8'hFF);
		load_byte(5'd2, 8'h5A);
		load_byte(5'd31, 8'hA5);
		// A tick while idle leaves everything as it is.
		time_tick();
		begin_transfer();
		time_tick();
		bus_event(ST_START, 8'hFF);
		bus_event(ST_AW_ACK, 8'h00);
		// Both bytes are out, so this ACK asks for the repeated START.
		bus_event(ST_DATA_ACK, 8'h00);
		bus_event(ST_RSTART, 8'h00);
		bus_event(ST_AR_ACK, 8'h00);
		bus_event(ST_RX_ACK, 8'h00);
		bus_event(ST_RX_NACK, 8'hFF);
		bus_event(ST_DATA_NACK, 8'h00);
		bus_event(ST_AW_NACK, 8'h00);
		bus_event(ST_AR_NACK, 8'h00);
		// Codes the sequencer does not know mean lost arbitration.
		bus_event(8'hFF, 8'h00);
		bus_event(8'h00, 8'h00);
		// Three ticks count up to the limit, the fourth times the transfer out,
		// and a tick after that no longer counts.
		begin_transfer();
		repeat (5) time_tick();
		wait_drained();

		for (ph = 0; ph < PHASE_COUNT; ph++) begin
			if (ph < FIXED_PHASES) begin
				wcount = PHASE_WCOUNT[ph];
				rcount = PHASE_RCOUNT[ph];
				limit = PHASE_LIMIT[ph];
			end else begin
				wcount = $urandom_range(0, 12);
				rcount = $urandom_range(0, 12);
				limit = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24'hFF_FFFF) :
					$urandom_range(0, 10);
			end
			write_config(wcount, rcount, limit);
			@(posedge clk);
			// Fill every slot once so that no transfer sends a byte never loaded.
			if (ph == 0)
				for (int s = 0; s < DEPTH; s++)
					load_byte(s, $urandom_range(0, 255));
			phase_first = issued_items;
			while (issued_items - phase_first < PHASE_ITEMS) begin
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 4)) noise_item();
				else
					run_transfer();
			end
			wait_drained();
		end

		// Let the pipeline settle so that a stray result would still be caught.
		repeat (4) @(posedge clk);
		$display("summary: %0d items in %0d cycles, %0d results checked, %0d config writes",
			accepted_items, cycle_count, checked_actions, cfg_writes);
		$display("summary: %0d bytes received, %0d timeouts, %0d mismatches",
			rx_bytes_seen, timeouts_seen, mismatches);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
